[hdl/hba_pkg.sv]
package hba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int WORD_BYTES   = 8;

    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 20;
    localparam int REQ_W      = 21;
    localparam int SIZE_W     = REQ_W + 1;
    localparam int WORD_SHIFT = $clog2(WORD_BYTES);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [REQ_W-1:0] ARENA_LIMIT = REQ_W'(1048576);
    localparam logic [REQ_W-1:0] ARENA_RESET = REQ_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_ARENA  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POLICY = CFG_IDX_W'(1);

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_FREE    = 1'b1;
    localparam logic FIT_FIRST  = 1'b0;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOMEM    = 2'd1;
    localparam logic [1:0] STAT_BAD_ADDR = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
        logic              busy;
    } entry_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_WR_SPLIT,
        S_WR_PICK,
        S_MERGE,
        S_SHIFT_DN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic init;
        logic accept;
        logic scan;
        logic decide;
        logic merge;
        logic shift;
        logic wr_split;
        logic wr_pick;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic arena_wr;
        logic scan_end;
        logic found;
        logic is_free;
        logic split;
        logic merge_shift;
        logic shift_done;
        logic out_free;
    } sts_t;

endpackage

[hdl/heap_block_allocator_core.sv]
// Heap allocator over an arena kept as an ordered table of up to 64 blocks in a
// single-port-write, registered-read table memory. Requests are handled one at a
// time. Each request first scans the table one entry per clock (first fit and
// free stop at the first hit). An allocation that splits a block then moves the
// entries above it up by one, one entry per cycle, and a free that merges with
// neighbors moves them down by one or two. The table memory port is what sets
// this pace.
// After reset, and after every write of the arena size, the table is rebuilt as
// one free block before the next request is taken; writes of the fit policy
// take effect at once. The result sits in an output register, so the next
// request is taken while an earlier result still waits.
module heap_block_allocator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [hba_pkg::REQ_W-1:0]       s_request_bytes,
    input  logic [hba_pkg::ADDR_W-1:0]      s_free_address,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hba_pkg::ADDR_W-1:0]      m_data_address,
    output logic [1:0]                      m_status,
    input  logic                            cfg_wr_en,
    input  logic [hba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // The controller sequences scan, decision, table moves and result; the
    // datapath owns the table, the configuration and the output register.
    hba_pkg::cmd_t cmd;
    hba_pkg::sts_t sts;

    hba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hba_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_operation     (s_operation),
        .s_request_bytes (s_request_bytes),
        .s_free_address  (s_free_address),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_address  (m_data_address),
        .m_status        (m_status)
    );

endmodule

[hdl/hba_datapath.sv]
module hba_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hba_pkg::cmd_t                   cmd,
    output hba_pkg::sts_t                   sts,
    input  logic                            s_operation,
    input  logic [hba_pkg::REQ_W-1:0]       s_request_bytes,
    input  logic [hba_pkg::ADDR_W-1:0]      s_free_address,
    input  logic                            cfg_wr_en,
    input  logic [hba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hba_pkg::ADDR_W-1:0]      m_data_address,
    output logic [1:0]                      m_status
);

    localparam logic [hba_pkg::SIZE_W-1:0] HDR = hba_pkg::SIZE_W'(hba_pkg::HEADER_BYTES);
    localparam logic [hba_pkg::CNT_W-1:0]  MAXC = hba_pkg::CNT_W'(hba_pkg::MAX_BLOCKS);

    hba_pkg::entry_t mem [hba_pkg::MAX_BLOCKS];
    hba_pkg::entry_t rdata_reg;
    hba_pkg::entry_t wdata;
    hba_pkg::entry_t last_reg;
    logic                       re, we;
    logic [hba_pkg::IDX_W-1:0]  raddr, waddr;

    logic [hba_pkg::REQ_W-1:0]  arena_reg;
    logic                       policy_reg;
    logic [hba_pkg::CNT_W-1:0]  count_reg;
    logic                       op_reg;
    logic [hba_pkg::SIZE_W-1:0] size_reg;
    logic [hba_pkg::ADDR_W-1:0] addr_reg;
    logic [hba_pkg::CNT_W-1:0]  rd_idx_reg;
    logic [hba_pkg::IDX_W-1:0]  chk_idx_reg;
    logic                       chk_vld_reg;
    logic                       found_reg;
    logic [hba_pkg::IDX_W-1:0]  pick_idx_reg;
    logic [hba_pkg::ADDR_W-1:0] pick_start_reg;
    logic [hba_pkg::ADDR_W-1:0] pick_len_reg;
    logic                       split_reg;
    logic                       next_ok_reg;
    logic [hba_pkg::CNT_W-1:0]  sh_src_reg, sh_lim_reg, sh_dst_reg;
    logic                       sh_up_reg, sh_pend_reg;
    logic [1:0]                 sh_dist_reg;
    logic                       out_valid_reg;
    logic [hba_pkg::ADDR_W-1:0] out_addr_reg;
    logic [1:0]                 out_status_reg;

    logic [hba_pkg::REQ_W-1:0]  arena_sat, arena_rnd;
    logic [hba_pkg::ADDR_W-1:0] init_len;
    logic [hba_pkg::SIZE_W-1:0] size_sum, size_rnd;
    logic                       first_mode, chk_en, cand, match;
    logic [hba_pkg::CNT_W-1:0]  pick_ext, pick_nxt;
    logic                       sh_more;
    logic                       p_free, n_free;
    logic [1:0]                 drop_cnt;
    logic [hba_pkg::SIZE_W-1:0] merge_len;
    logic [hba_pkg::SIZE_W-1:0] alloc_addr;

    always_comb begin
        arena_sat = (arena_reg > hba_pkg::ARENA_LIMIT) ? hba_pkg::ARENA_LIMIT : arena_reg;
        arena_rnd = {arena_sat[hba_pkg::REQ_W-1:hba_pkg::WORD_SHIFT],
                     {hba_pkg::WORD_SHIFT{1'b0}}};
        init_len  = (arena_rnd > hba_pkg::REQ_W'(hba_pkg::HEADER_BYTES))
                  ? hba_pkg::ADDR_W'(arena_rnd - hba_pkg::REQ_W'(hba_pkg::HEADER_BYTES))
                  : '0;
        size_sum  = {1'b0, s_request_bytes} + hba_pkg::SIZE_W'(hba_pkg::WORD_BYTES - 1);
        size_rnd  = {size_sum[hba_pkg::SIZE_W-1:hba_pkg::WORD_SHIFT],
                     {hba_pkg::WORD_SHIFT{1'b0}}};
    end

    // Scan evaluation of the entry whose read returned this cycle, plus the shift, merge and allocation-address terms.
    always_comb begin
        first_mode = (op_reg == hba_pkg::OP_FREE) || (policy_reg == hba_pkg::FIT_FIRST);
        chk_en     = cmd.scan && chk_vld_reg && !(found_reg && first_mode);
        cand       = !rdata_reg.busy && ({2'b0, rdata_reg.len} >= size_reg);
        match      = ({1'b0, rdata_reg.start} + hba_pkg::REQ_W'(hba_pkg::HEADER_BYTES))
                     == {1'b0, addr_reg};
        pick_ext   = {1'b0, pick_idx_reg};
        pick_nxt   = pick_ext + 1'b1;
        sh_more    = sh_up_reg ? (sh_src_reg > sh_lim_reg) : (sh_src_reg < sh_lim_reg);
        p_free     = (pick_idx_reg != '0) && !last_reg.busy;
        n_free     = next_ok_reg && !rdata_reg.busy;
        drop_cnt   = {1'b0, p_free} + {1'b0, n_free};
        merge_len  = {2'b0, pick_len_reg}
                   + (p_free ? ({2'b0, last_reg.len} + HDR) : '0)
                   + (n_free ? ({2'b0, rdata_reg.len} + HDR) : '0);
        alloc_addr = {2'b0, pick_start_reg} + HDR;
    end

    always_comb begin
        sts.arena_wr    = cfg_wr_en && (cfg_index == hba_pkg::REG_ARENA);
        sts.scan_end    = (found_reg && first_mode) || (!chk_vld_reg && rd_idx_reg >= count_reg);
        sts.found       = found_reg;
        sts.is_free     = op_reg == hba_pkg::OP_FREE;
        sts.split       = ({2'b0, pick_len_reg} > size_reg + HDR) && (count_reg < MAXC);
        sts.merge_shift = p_free || n_free;
        sts.shift_done  = !sh_more && !sh_pend_reg;
        sts.out_free    = !out_valid_reg || m_ready;
    end

    // Table port selection.
    always_comb begin
        re    = 1'b0;
        we    = 1'b0;
        raddr = '0;
        waddr = '0;
        wdata = '0;
        if (cmd.init) begin
            we    = 1'b1;
            wdata = '{start: '0, len: init_len, busy: 1'b0};
        end
        if (cmd.scan && rd_idx_reg < count_reg) begin
            re    = 1'b1;
            raddr = rd_idx_reg[hba_pkg::IDX_W-1:0];
        end
        if (cmd.decide && found_reg && op_reg == hba_pkg::OP_FREE && pick_nxt < count_reg) begin
            re    = 1'b1;
            raddr = pick_nxt[hba_pkg::IDX_W-1:0];
        end
        if (cmd.shift) begin
            if (sh_more) begin
                re    = 1'b1;
                raddr = sh_src_reg[hba_pkg::IDX_W-1:0];
            end
            if (sh_pend_reg) begin
                we    = 1'b1;
                waddr = sh_dst_reg[hba_pkg::IDX_W-1:0];
                wdata = rdata_reg;
            end
        end
        if (cmd.merge) begin
            we = 1'b1;
            if (p_free) begin
                waddr = pick_idx_reg - 1'b1;
                wdata = '{start: last_reg.start, len: merge_len[hba_pkg::ADDR_W-1:0],
                          busy: 1'b0};
            end else begin
                waddr = pick_idx_reg;
                wdata = '{start: pick_start_reg, len: merge_len[hba_pkg::ADDR_W-1:0],
                          busy: 1'b0};
            end
        end
        if (cmd.wr_split) begin
            we    = 1'b1;
            waddr = pick_nxt[hba_pkg::IDX_W-1:0];
            wdata = '{start: hba_pkg::ADDR_W'(alloc_addr + size_reg),
                      len:   hba_pkg::ADDR_W'({2'b0, pick_len_reg} - size_reg - HDR),
                      busy:  1'b0};
        end
        if (cmd.wr_pick) begin
            we    = 1'b1;
            waddr = pick_idx_reg;
            wdata = '{start: pick_start_reg,
                      len:   split_reg ? size_reg[hba_pkg::ADDR_W-1:0] : pick_len_reg,
                      busy:  1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arena_reg     <= hba_pkg::ARENA_RESET;
            policy_reg    <= hba_pkg::FIT_FIRST;
            count_reg     <= hba_pkg::CNT_W'(1);
            rd_idx_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            sh_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == hba_pkg::REG_ARENA) begin
                arena_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == hba_pkg::REG_POLICY) begin
                policy_reg <= cfg_wdata[0];
            end
            if (cmd.init) begin
                count_reg <= hba_pkg::CNT_W'(1);
            end else if (cmd.merge) begin
                count_reg <= count_reg - hba_pkg::CNT_W'(drop_cnt);
            end else if (cmd.wr_split) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.accept) begin
                rd_idx_reg  <= '0;
                chk_vld_reg <= 1'b0;
                found_reg   <= 1'b0;
            end else if (cmd.scan) begin
                chk_vld_reg <= rd_idx_reg < count_reg;
                if (rd_idx_reg < count_reg) begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (chk_en && ((op_reg == hba_pkg::OP_FREE) ? match
                        : (cand && (!found_reg || (!first_mode && rdata_reg.len < pick_len_reg))))) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.shift) begin
                sh_pend_reg <= sh_more;
            end else begin
                sh_pend_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_operation;
            size_reg <= size_rnd;
            addr_reg <= s_free_address;
        end
        if (cmd.scan) begin
            chk_idx_reg <= rd_idx_reg[hba_pkg::IDX_W-1:0];
        end
        if (chk_en) begin
            if (op_reg == hba_pkg::OP_FREE) begin
                if (match) begin
                    pick_idx_reg   <= chk_idx_reg;
                    pick_start_reg <= rdata_reg.start;
                    pick_len_reg   <= rdata_reg.len;
                end else begin
                    last_reg <= rdata_reg;
                end
            end else if (cand && (!found_reg
                    || (!first_mode && rdata_reg.len < pick_len_reg))) begin
                pick_idx_reg   <= chk_idx_reg;
                pick_start_reg <= rdata_reg.start;
                pick_len_reg   <= rdata_reg.len;
            end
        end
        if (cmd.decide) begin
            split_reg   <= sts.split;
            next_ok_reg <= pick_nxt < count_reg;
            sh_src_reg  <= count_reg - 1'b1;
            sh_lim_reg  <= pick_ext;
            sh_up_reg   <= 1'b1;
        end
        if (cmd.merge) begin
            sh_src_reg  <= (p_free ? pick_ext : pick_nxt) + hba_pkg::CNT_W'(drop_cnt);
            sh_lim_reg  <= count_reg;
            sh_up_reg   <= 1'b0;
            sh_dist_reg <= drop_cnt;
        end
        if (cmd.shift && sh_more) begin
            if (sh_up_reg) begin
                sh_dst_reg <= sh_src_reg + 1'b1;
                sh_src_reg <= sh_src_reg - 1'b1;
            end else begin
                sh_dst_reg <= sh_src_reg - hba_pkg::CNT_W'(sh_dist_reg);
                sh_src_reg <= sh_src_reg + 1'b1;
            end
        end
        if (cmd.out_load) begin
            if (!found_reg) begin
                out_addr_reg   <= '0;
                out_status_reg <= (op_reg == hba_pkg::OP_FREE) ? hba_pkg::STAT_BAD_ADDR
                                                               : hba_pkg::STAT_NOMEM;
            end else begin
                out_addr_reg   <= (op_reg == hba_pkg::OP_FREE) ? '0
                                                               : alloc_addr[hba_pkg::ADDR_W-1:0];
                out_status_reg <= hba_pkg::STAT_OK;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_data_address = out_addr_reg;
    assign m_status       = out_status_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= hba_pkg::CNT_W'(1)) && (count_reg <= MAXC))
        else $error("block count out of range");

    a_shift_dst: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift && sh_pend_reg) |-> (sh_dst_reg < MAXC))
        else $error("shift write beyond table");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

endmodule

[hdl/hba_ctrl.sv]
module hba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hba_pkg::sts_t sts,
    output hba_pkg::cmd_t cmd
);

    hba_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hba_pkg::S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hba_pkg::S_INIT:     state_next = hba_pkg::S_IDLE;
            hba_pkg::S_IDLE:     if (s_valid) state_next = hba_pkg::S_SCAN;
            hba_pkg::S_SCAN:     if (sts.scan_end) state_next = hba_pkg::S_DECIDE;
            hba_pkg::S_DECIDE: begin
                if (!sts.found) begin
                    state_next = hba_pkg::S_RESULT;
                end else if (sts.is_free) begin
                    state_next = hba_pkg::S_MERGE;
                end else if (sts.split) begin
                    state_next = hba_pkg::S_SHIFT_UP;
                end else begin
                    state_next = hba_pkg::S_WR_PICK;
                end
            end
            hba_pkg::S_SHIFT_UP: if (sts.shift_done) state_next = hba_pkg::S_WR_SPLIT;
            hba_pkg::S_WR_SPLIT: state_next = hba_pkg::S_WR_PICK;
            hba_pkg::S_WR_PICK:  state_next = hba_pkg::S_RESULT;
            hba_pkg::S_MERGE: begin
                state_next = sts.merge_shift ? hba_pkg::S_SHIFT_DN : hba_pkg::S_RESULT;
            end
            hba_pkg::S_SHIFT_DN: if (sts.shift_done) state_next = hba_pkg::S_RESULT;
            hba_pkg::S_RESULT:   if (sts.out_free) state_next = hba_pkg::S_IDLE;
            default:             state_next = hba_pkg::S_INIT;
        endcase
        if (sts.arena_wr) begin
            state_next = hba_pkg::S_INIT;
        end
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            hba_pkg::S_INIT:     cmd.init = 1'b1;
            hba_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            hba_pkg::S_SCAN:     cmd.scan = 1'b1;
            hba_pkg::S_DECIDE:   cmd.decide = 1'b1;
            hba_pkg::S_SHIFT_UP: cmd.shift = 1'b1;
            hba_pkg::S_WR_SPLIT: cmd.wr_split = 1'b1;
            hba_pkg::S_WR_PICK:  cmd.wr_pick = 1'b1;
            hba_pkg::S_MERGE:    cmd.merge = 1'b1;
            hba_pkg::S_SHIFT_DN: cmd.shift = 1'b1;
            hba_pkg::S_RESULT:   cmd.out_load = sts.out_free;
            default:             cmd = '0;
        endcase
    end

endmodule
